// ----- src/sorted_membership_toggle_defines.svh -----
// Assertion macros used by the sorted_membership_toggle RTL file.
`ifndef SORTED_MEMBERSHIP_TOGGLE_DEFINES_SVH
`define SORTED_MEMBERSHIP_TOGGLE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside of reset.
`define SMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside of reset.
`define SMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/smt_pkg.sv -----
package smt_pkg;

  // List geometry: members are 4-bit column indices, so a list holds at most 16.
  localparam int DEPTH = 16;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;

  // Column count limits.
  localparam int MIN_COLUMNS = 3;
  localparam int DEF_MAX_COLUMNS = 16;

  // Action codes reported with every emitted entry.
  typedef enum logic [2:0] {
    ACT_ADDED     = 3'd0,
    ACT_REMOVED   = 3'd1,
    ACT_KEPT      = 3'd2,
    ACT_REJECTED  = 3'd3,
    ACT_RESTARTED = 3'd4
  } act_t;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_TOGGLE_A = 2'd0,
    KIND_TOGGLE_B = 2'd1,
    KIND_RESTART  = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_DN,
    ST_SHIFT_UP,
    ST_EMIT
  } state_t;

  // Request from the sequencer to the list store.
  typedef struct packed {
    logic             sel_b;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] wr_data;
    logic             cnt_we;
    logic [CNT_W-1:0] cnt_data;
    logic             load;
    logic [CNT_W-1:0] load_cols;
  } cmd_t;

  // Largest usable column count for a given build limit.
  function automatic int top_cols(input int max_columns);
    int t;
    t = (max_columns < DEPTH) ? max_columns : DEPTH;
    if (t < MIN_COLUMNS) begin
      t = MIN_COLUMNS;
    end
    return t;
  endfunction

endpackage

// ----- src/sorted_membership_toggle.sv -----
// Sorted membership toggle: two ascending lists of distinct column indices.
// Input: an item is taken when start is high and busy is low. kind 0 or 1
// toggles in_column in list A or B, kind 2 restarts both lists, kind 3 is
// dropped without results. Configuration: cfg_data (column count) is written
// when cfg_valid and cfg_ready are high; cfg_ready is always high, and writes
// belong to idle periods only.
// Output: after each item the touched list (A after a restart) is emitted one
// entry per cycle on consecutive cycles, marked by out_valid, with out_last on
// the final entry. Each entry is shown for exactly one cycle; there is no
// back-pressure.
// Timing: one shared compare/index unit walks the list one entry per cycle.
// A toggle first scans the list and shifts entries to insert or remove the
// column, then emits the new list one entry per cycle. The outputs are
// registered from the emit state, and the next item can be taken at the edge
// that ends the last entry.
// Reset: column count goes to min(MAX_COLUMNS, 16), but at least 3, A holds {0,1}
// and B holds 2 up to the column count minus one; the block is idle after reset.
`include "sorted_membership_toggle_defines.svh"

module sorted_membership_toggle #(
  parameter int MAX_COLUMNS = smt_pkg::DEF_MAX_COLUMNS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_kind,
  input  logic [3:0] in_column,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data,
  output logic       out_valid,
  output logic [2:0] out_action,
  output logic [3:0] out_position,
  output logic [3:0] out_member,
  output logic [4:0] out_member_count,
  output logic       out_last
);

  localparam int TOP_COLS = smt_pkg::top_cols(MAX_COLUMNS);
  localparam logic [smt_pkg::CNT_W-1:0] TopCnt = smt_pkg::CNT_W'(TOP_COLS);
  localparam logic [smt_pkg::CNT_W-1:0] MinCnt = smt_pkg::CNT_W'(smt_pkg::MIN_COLUMNS);
  localparam logic [smt_pkg::CNT_W-1:0] FullCnt = smt_pkg::CNT_W'(smt_pkg::DEPTH);

  smt_pkg::state_t state_r, state_nxt;
  logic [smt_pkg::CNT_W-1:0] column_count_r;
  logic                      sel_b_r, sel_b_nxt;
  logic [smt_pkg::IDX_W-1:0] col_r, col_nxt;
  smt_pkg::act_t             act_r, act_nxt;
  logic [smt_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic [smt_pkg::CNT_W-1:0] pos_r, pos_nxt;

  smt_pkg::cmd_t             cmd;
  logic [smt_pkg::IDX_W-1:0] rd_data;
  logic [smt_pkg::CNT_W-1:0] n;

  logic       accept;
  logic       in_range;
  logic       scan_end, scan_hit, scan_past;
  logic       dn_done, up_more, emit_last;

  logic       out_valid_r;
  logic [2:0] out_action_r;
  logic [3:0] out_position_r;
  logic [3:0] out_member_r;
  logic [4:0] out_member_count_r;
  logic       out_last_r;

  smt_store #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .rd_data   (rd_data),
    .cur_count (n)
  );

  // Configuration register with range clamp.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= TopCnt;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data < MinCnt) begin
        column_count_r <= MinCnt;
      end else if (cfg_data > TopCnt) begin
        column_count_r <= TopCnt;
      end else begin
        column_count_r <= cfg_data;
      end
    end
  end

  // Conditions evaluated by the shared compare unit.
  assign accept    = start && !busy;
  assign in_range  = {1'b0, in_column} < column_count_r;
  assign scan_end  = idx_r == n;
  assign scan_hit  = rd_data == col_r;
  assign scan_past = rd_data > col_r;
  assign dn_done   = (idx_r + smt_pkg::CNT_W'(1)) >= n;
  assign up_more   = idx_r > pos_r;
  assign emit_last = (idx_r + smt_pkg::CNT_W'(1)) == n;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      smt_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (smt_pkg::kind_t'(in_kind))
            smt_pkg::KIND_TOGGLE_A,
            smt_pkg::KIND_TOGGLE_B: state_nxt = in_range ? smt_pkg::ST_SCAN
                                                         : smt_pkg::ST_EMIT;
            smt_pkg::KIND_RESTART:  state_nxt = smt_pkg::ST_EMIT;
            default:                state_nxt = smt_pkg::ST_IDLE;
          endcase
        end
      end
      smt_pkg::ST_SCAN: begin
        priority if (scan_end) begin
          state_nxt = (n == FullCnt) ? smt_pkg::ST_EMIT : smt_pkg::ST_SHIFT_UP;
        end else if (scan_hit) begin
          state_nxt = (n <= smt_pkg::CNT_W'(1)) ? smt_pkg::ST_EMIT : smt_pkg::ST_SHIFT_DN;
        end else if (scan_past) begin
          state_nxt = smt_pkg::ST_SHIFT_UP;
        end else begin
          state_nxt = smt_pkg::ST_SCAN;
        end
      end
      smt_pkg::ST_SHIFT_DN: begin
        if (dn_done) begin
          state_nxt = smt_pkg::ST_EMIT;
        end
      end
      smt_pkg::ST_SHIFT_UP: begin
        if (!up_more) begin
          state_nxt = smt_pkg::ST_EMIT;
        end
      end
      smt_pkg::ST_EMIT: begin
        if (emit_last) begin
          state_nxt = smt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = smt_pkg::ST_IDLE;
    endcase
  end

  // Working registers of the sequencer.
  always_comb begin
    sel_b_nxt = sel_b_r;
    col_nxt   = col_r;
    act_nxt   = act_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    unique case (state_r)
      smt_pkg::ST_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          sel_b_nxt = smt_pkg::kind_t'(in_kind) == smt_pkg::KIND_TOGGLE_B;
          col_nxt   = in_column;
          act_nxt   = in_range ? smt_pkg::ACT_ADDED : smt_pkg::ACT_REJECTED;
          if (smt_pkg::kind_t'(in_kind) == smt_pkg::KIND_RESTART) begin
            sel_b_nxt = 1'b0;
            act_nxt   = smt_pkg::ACT_RESTARTED;
          end
        end
      end
      smt_pkg::ST_SCAN: begin
        priority if (scan_end) begin
          // Not found: insert at the tail, or reject when the list is full.
          pos_nxt = n;
          if (n == FullCnt) begin
            act_nxt = smt_pkg::ACT_REJECTED;
            idx_nxt = '0;
          end
        end else if (scan_hit) begin
          if (n <= smt_pkg::CNT_W'(1)) begin
            act_nxt = smt_pkg::ACT_KEPT;
            idx_nxt = '0;
          end else begin
            act_nxt = smt_pkg::ACT_REMOVED;
          end
        end else if (scan_past) begin
          pos_nxt = idx_r;
          idx_nxt = n;
        end else begin
          idx_nxt = idx_r + smt_pkg::CNT_W'(1);
        end
      end
      smt_pkg::ST_SHIFT_DN: begin
        idx_nxt = dn_done ? '0 : idx_r + smt_pkg::CNT_W'(1);
      end
      smt_pkg::ST_SHIFT_UP: begin
        idx_nxt = up_more ? idx_r - smt_pkg::CNT_W'(1) : '0;
      end
      smt_pkg::ST_EMIT: begin
        idx_nxt = idx_r + smt_pkg::CNT_W'(1);
      end
      default: idx_nxt = '0;
    endcase
  end

  // Store requests and handshake outputs.
  always_comb begin
    cmd           = '0;
    cmd.sel_b     = sel_b_r;
    cmd.rd_idx    = idx_r[smt_pkg::IDX_W-1:0];
    cmd.wr_idx    = idx_r[smt_pkg::IDX_W-1:0];
    cmd.wr_data   = rd_data;
    cmd.load_cols = column_count_r;
    busy          = state_r != smt_pkg::ST_IDLE;
    unique case (state_r)
      smt_pkg::ST_IDLE: begin
        cmd.load = accept && (smt_pkg::kind_t'(in_kind) == smt_pkg::KIND_RESTART);
      end
      smt_pkg::ST_SCAN: begin
      end
      smt_pkg::ST_SHIFT_DN: begin
        // Pull the next entry down over the removed one.
        cmd.rd_idx   = smt_pkg::IDX_W'(idx_r + smt_pkg::CNT_W'(1));
        cmd.wr_en    = !dn_done;
        cmd.cnt_we   = dn_done;
        cmd.cnt_data = n - smt_pkg::CNT_W'(1);
      end
      smt_pkg::ST_SHIFT_UP: begin
        // Push entries up from the tail, then drop the new column in.
        cmd.rd_idx   = smt_pkg::IDX_W'(idx_r - smt_pkg::CNT_W'(1));
        cmd.wr_en    = 1'b1;
        cmd.wr_data  = up_more ? rd_data : col_r;
        cmd.cnt_we   = !up_more;
        cmd.cnt_data = n + smt_pkg::CNT_W'(1);
      end
      smt_pkg::ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smt_pkg::ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_b_r <= sel_b_nxt;
    col_r   <= col_nxt;
    act_r   <= act_nxt;
    pos_r   <= pos_nxt;
  end

  // Output register: one entry per cycle while emitting.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= state_r == smt_pkg::ST_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    out_action_r       <= act_r;
    out_position_r     <= idx_r[smt_pkg::IDX_W-1:0];
    out_member_r       <= rd_data;
    out_member_count_r <= n;
    out_last_r         <= emit_last;
  end

  assign out_valid        = out_valid_r;
  assign out_action       = out_action_r;
  assign out_position     = out_position_r;
  assign out_member       = out_member_r;
  assign out_member_count = out_member_count_r;
  assign out_last         = out_last_r;

  // A list is emitted on consecutive cycles and ends with its last entry.
  `SMT_ASSERT_NEXT(a_emit_runs, out_valid && !out_last, out_valid, "emitted list broke off early")
  `SMT_ASSERT_NEXT(a_emit_gap, out_valid && out_last, !out_valid, "emission ran past last entry")
  // Every accepted meaningful item keeps the block busy next cycle.
  `SMT_ASSERT_NEXT(a_busy_after, start && !busy && smt_pkg::kind_t'(in_kind) != smt_pkg::KIND_NONE, busy, "item not taken up")
  // Entries lie inside a non-empty list.
  `SMT_ASSERT_NOW(a_pos_range, out_valid, out_member_count != 5'd0 && {1'b0, out_position} < out_member_count, "emitted position outside list")

endmodule

// ----- src/smt_store.sv -----
module smt_store #(
  parameter int MAX_COLUMNS = smt_pkg::DEF_MAX_COLUMNS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  smt_pkg::cmd_t           cmd,
  output logic [smt_pkg::IDX_W-1:0] rd_data,
  output logic [smt_pkg::CNT_W-1:0] cur_count
);

  localparam int RESET_COLS = smt_pkg::top_cols(MAX_COLUMNS);

  logic [smt_pkg::IDX_W-1:0] list_a_r [smt_pkg::DEPTH];
  logic [smt_pkg::IDX_W-1:0] list_b_r [smt_pkg::DEPTH];
  logic [smt_pkg::CNT_W-1:0] count_a_r;
  logic [smt_pkg::CNT_W-1:0] count_b_r;

  // One read port on the selected list.
  assign rd_data   = cmd.sel_b ? list_b_r[cmd.rd_idx] : list_a_r[cmd.rd_idx];
  assign cur_count = cmd.sel_b ? count_b_r : count_a_r;

  // Restart and reset load A with {0,1} and B with 2 upward; the count bounds B.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      for (int i = 0; i < smt_pkg::DEPTH; i++) begin
        list_a_r[i] <= smt_pkg::IDX_W'(i);
        list_b_r[i] <= smt_pkg::IDX_W'(i + 2);
      end
      count_a_r <= smt_pkg::CNT_W'(2);
      if (!rst_n) begin
        count_b_r <= smt_pkg::CNT_W'(RESET_COLS - 2);
      end else begin
        count_b_r <= cmd.load_cols - smt_pkg::CNT_W'(2);
      end
    end else begin
      if (cmd.wr_en) begin
        if (cmd.sel_b) begin
          list_b_r[cmd.wr_idx] <= cmd.wr_data;
        end else begin
          list_a_r[cmd.wr_idx] <= cmd.wr_data;
        end
      end
      if (cmd.cnt_we) begin
        if (cmd.sel_b) begin
          count_b_r <= cmd.cnt_data;
        end else begin
          count_a_r <= cmd.cnt_data;
        end
      end
    end
  end

endmodule
